### rtl/ipv6_longest_prefix_match_trie_defines.svh
// Assertion macros used by the trie walk sequencer (ipv6lpm_walk).
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef IPV6_LONGEST_PREFIX_MATCH_TRIE_DEFINES_SVH
`define IPV6_LONGEST_PREFIX_MATCH_TRIE_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define IPV6LPM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define IPV6LPM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ipv6lpm_pkg.sv
package ipv6lpm_pkg;

  // Fixed field widths
  localparam int POP_W   = 16;
  localparam int LEN_W   = 8;
  localparam int ADDR_W  = 128;

  // Parameter defaults
  localparam int NODE_COUNT_DEF = 4096;
  localparam int ADDR_BITS_DEF  = 128;

  // Request kinds
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  // Request control fields (address travels separately, its width is a parameter)
  typedef struct packed {
    logic             req_type;
    logic [LEN_W-1:0] prefix_len;
    logic [POP_W-1:0] pop_value;
  } req_ctl_t;

  // Result of one request
  typedef struct packed {
    logic             table_full;
    logic [LEN_W-1:0] match_scope;
    logic [POP_W-1:0] match_pop;
  } res_t;

  // Walk sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_STEP,
    S_DONE
  } walk_state_t;

endpackage

### rtl/ipv6lpm_node_ram.sv
module ipv6lpm_node_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 49,
  parameter int AW    = 12
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/ipv6lpm_walk.sv
module ipv6lpm_walk #(
  parameter int NODE_COUNT = 4096,
  parameter int ADDR_BITS  = 128,
  parameter int IDXW       = 12,
  parameter int NW         = 49
) (
  input  logic                  clk,
  input  logic                  rst,
  // request side
  input  logic                  req_valid,
  output logic                  req_ready,
  input  ipv6lpm_pkg::req_ctl_t req,
  input  logic [ADDR_BITS-1:0]  req_addr,
  // result side
  output logic                  res_valid,
  input  logic                  res_ready,
  output ipv6lpm_pkg::res_t     res,
  // node memory port
  output logic                  mem_we,
  output logic [IDXW-1:0]       mem_waddr,
  output logic [NW-1:0]         mem_wdata,
  output logic                  mem_re,
  output logic [IDXW-1:0]       mem_raddr,
  input  logic [NW-1:0]         mem_rdata
);

  import ipv6lpm_pkg::*;

  `include "ipv6_longest_prefix_match_trie_defines.svh"

  // Node layout: pop, scope, valid, child 0, child 1 (lowest bit up)
  localparam int SCOPE_LSB = POP_W;
  localparam int VALID_BIT = POP_W + LEN_W;
  localparam int C0_LSB    = VALID_BIT + 1;
  localparam int C1_LSB    = C0_LSB + IDXW;
  localparam int FW        = $clog2(NODE_COUNT + 1);
  localparam logic [LEN_W-1:0] MaxLen   = LEN_W'(ADDR_BITS);
  localparam logic [FW-1:0]    PoolSize = FW'(NODE_COUNT);

  walk_state_t state, state_next;

  // control state
  logic [FW-1:0]     free, free_next;
  logic [NW-1:0]     root_node, root_next;
  logic              use_rd, use_rd_next;
  logic              fresh, fresh_next;

  // per-request working registers
  logic [IDXW-1:0]      cur, cur_next;
  logic [NW-1:0]        node_q, node_q_next;
  logic [LEN_W-1:0]     depth, depth_next;
  logic [LEN_W-1:0]     len, len_next;
  logic [ADDR_BITS-1:0] addr_sh, addr_sh_next;
  logic                 is_lookup, is_lookup_next;
  logic [POP_W-1:0]     pop_q, pop_q_next;
  logic [POP_W-1:0]     best_pop, best_pop_next;
  logic [LEN_W-1:0]     best_scope, best_scope_next;
  logic                 full, full_next;

  // datapath around the current node
  logic [NW-1:0]   nv;
  logic [IDXW-1:0] child;
  logic            dir;
  logic            at_end;
  logic            pool_empty;
  logic [IDXW-1:0] free_idx;
  logic [NW-1:0]   linked;
  logic [NW-1:0]   rule;
  logic            wr_en;
  logic [NW-1:0]   wr_data;

  // current node comes from the memory read just issued, or from the local copy
  assign nv         = use_rd ? mem_rdata : node_q;
  assign dir        = addr_sh[ADDR_BITS-1];
  assign child      = dir ? nv[C1_LSB +: IDXW] : nv[C0_LSB +: IDXW];
  assign at_end     = (depth == len);
  assign pool_empty = (free >= PoolSize);
  assign free_idx   = free[IDXW-1:0];

  // node with a new child hooked in, and node with the rule recorded
  always_comb begin
    linked = nv;
    if (dir) begin
      linked[C1_LSB +: IDXW] = free_idx;
    end else begin
      linked[C0_LSB +: IDXW] = free_idx;
    end
    rule = nv;
    rule[POP_W-1:0]             = pop_q;
    rule[SCOPE_LSB +: LEN_W]    = len;
    rule[VALID_BIT]             = 1'b1;
  end

  // sequencer
  always_comb begin
    state_next      = state;
    free_next       = free;
    use_rd_next     = use_rd;
    fresh_next      = fresh;
    cur_next        = cur;
    node_q_next     = node_q;
    depth_next      = depth;
    len_next        = len;
    addr_sh_next    = addr_sh;
    is_lookup_next  = is_lookup;
    pop_q_next      = pop_q;
    best_pop_next   = best_pop;
    best_scope_next = best_scope;
    full_next       = full;
    wr_en           = 1'b0;
    wr_data         = nv;
    mem_re          = 1'b0;
    mem_raddr       = child;
    req_ready       = 1'b0;
    res_valid       = 1'b0;

    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cur_next       = '0;
          node_q_next    = root_node;
          use_rd_next    = 1'b0;
          fresh_next     = 1'b0;
          depth_next     = '0;
          len_next       = (req.prefix_len > MaxLen) ? MaxLen : req.prefix_len;
          addr_sh_next   = req_addr;
          is_lookup_next = (req.req_type == REQ_LOOKUP);
          pop_q_next     = req.pop_value;
          full_next      = 1'b0;
          // the root rule counts for a lookup
          if ((req.req_type == REQ_LOOKUP) && root_node[VALID_BIT]) begin
            best_pop_next   = root_node[POP_W-1:0];
            best_scope_next = root_node[SCOPE_LSB +: LEN_W];
          end else begin
            best_pop_next   = '0;
            best_scope_next = '0;
          end
          state_next = S_STEP;
        end
      end

      S_STEP: begin
        if (is_lookup) begin
          // arrived at a child: take its rule if it has one
          if (use_rd && nv[VALID_BIT]) begin
            best_pop_next   = nv[POP_W-1:0];
            best_scope_next = nv[SCOPE_LSB +: LEN_W];
          end
          if (!at_end && (child != '0)) begin
            mem_re       = 1'b1;
            cur_next     = child;
            use_rd_next  = 1'b1;
            depth_next   = depth + LEN_W'(1);
            addr_sh_next = {addr_sh[ADDR_BITS-2:0], 1'b0};
          end else begin
            state_next = S_DONE;
          end
        end else begin
          priority if (at_end) begin
            // record the rule at the end node
            wr_en      = 1'b1;
            wr_data    = rule;
            state_next = S_DONE;
          end else if (child != '0) begin
            // descend into an existing child
            mem_re       = 1'b1;
            cur_next     = child;
            use_rd_next  = 1'b1;
            fresh_next   = 1'b0;
            depth_next   = depth + LEN_W'(1);
            addr_sh_next = {addr_sh[ADDR_BITS-2:0], 1'b0};
          end else if (pool_empty) begin
            // out of nodes: a freshly allocated node still has to reach memory
            wr_en      = fresh;
            wr_data    = nv;
            full_next  = 1'b1;
            state_next = S_DONE;
          end else begin
            // allocate a child and link it into the current node
            wr_en        = 1'b1;
            wr_data      = linked;
            cur_next     = free_idx;
            node_q_next  = '0;
            use_rd_next  = 1'b0;
            fresh_next   = 1'b1;
            free_next    = free + FW'(1);
            depth_next   = depth + LEN_W'(1);
            addr_sh_next = {addr_sh[ADDR_BITS-2:0], 1'b0};
          end
        end
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // root lives in flops, every other node in memory
  assign mem_we    = wr_en && (cur != '0);
  assign mem_waddr = cur;
  assign mem_wdata = wr_data;
  assign root_next = (wr_en && (cur == '0)) ? wr_data : root_node;

  assign res.match_pop   = best_pop;
  assign res.match_scope = best_scope;
  assign res.table_full  = full;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      free      <= FW'(1);
      root_node <= '0;
      use_rd    <= 1'b0;
      fresh     <= 1'b0;
    end else begin
      state     <= state_next;
      free      <= free_next;
      root_node <= root_next;
      use_rd    <= use_rd_next;
      fresh     <= fresh_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    cur        <= cur_next;
    node_q     <= node_q_next;
    depth      <= depth_next;
    len        <= len_next;
    addr_sh    <= addr_sh_next;
    is_lookup  <= is_lookup_next;
    pop_q      <= pop_q_next;
    best_pop   <= best_pop_next;
    best_scope <= best_scope_next;
    full       <= full_next;
  end

  `IPV6LPM_ASSERT_IMP(a_pool_bound, 1'b1, free <= PoolSize, "node counter beyond pool")
  `IPV6LPM_ASSERT_IMP(a_lookup_no_write, (state == S_STEP) && is_lookup, !wr_en,
                      "lookup wrote the trie")
  `IPV6LPM_ASSERT_IMP(a_depth_bound, state == S_STEP, depth <= len, "walk past prefix length")
  `IPV6LPM_ASSERT_IMP(a_full_on_insert, res_valid && full, !is_lookup, "table_full on lookup")
  `IPV6LPM_ASSERT_NXT(a_done_hold, (state == S_DONE) && !res_ready, state == S_DONE,
                      "result dropped before taken")

endmodule

### rtl/ipv6_longest_prefix_match_trie.sv
// Channel  Dir  tdata (low bit up)                                tuser
// s_*      in   addr_hi[63:0] addr_lo[127:64] prefix_len[135:128]   req_type
//               pop_value[151:136]
// m_*      out  match_pop[15:0] match_scope[23:16]                 table_full
//
// A request is taken in S_IDLE; S_STEP then visits one node per level on the path (root
// included), down to depth min(prefix_len, ADDR_BITS), and S_DONE hands the result over.
// A lookup that meets a missing child, or an insert that runs out of nodes, stops above that depth.
// The node memory is walked one read or write per level; no request overlaps another.
// Reset clears the root node (held in flops) and the allocation counter; no clearing pass.
// A stalled result waits in the output register while the next request is taken; the
// walk then holds its own result until that register frees up.
module ipv6_longest_prefix_match_trie #(
  parameter int NODE_COUNT = ipv6lpm_pkg::NODE_COUNT_DEF,
  parameter int ADDR_BITS  = ipv6lpm_pkg::ADDR_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [151:0] s_tdata,   // addr_hi, addr_lo, prefix_len, pop_value
  input  logic [0:0]   s_tuser,   // req_type
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [23:0]  m_tdata,   // match_pop, match_scope
  output logic [0:0]   m_tuser    // table_full
);

  import ipv6lpm_pkg::*;

  localparam int IDXW = $clog2(NODE_COUNT);
  localparam int NW   = POP_W + LEN_W + 1 + 2 * IDXW;

  req_ctl_t             req;
  logic [ADDR_W-1:0]    addr_full;
  logic [ADDR_BITS-1:0] req_addr;
  res_t                 res;
  logic                 res_valid;
  logic                 res_ready;
  logic                 mem_we;
  logic [IDXW-1:0]      mem_waddr;
  logic [NW-1:0]        mem_wdata;
  logic                 mem_re;
  logic [IDXW-1:0]      mem_raddr;
  logic [NW-1:0]        mem_rdata;
  res_t                 out_q;

  // unpack the input transaction; only the top ADDR_BITS address bits are walked
  assign addr_full      = {s_tdata[63:0], s_tdata[127:64]};
  assign req_addr       = addr_full[ADDR_W-1 -: ADDR_BITS];
  assign req.req_type   = s_tuser[0];
  assign req.prefix_len = s_tdata[135:128];
  assign req.pop_value  = s_tdata[151:136];

  ipv6lpm_walk #(
    .NODE_COUNT (NODE_COUNT),
    .ADDR_BITS  (ADDR_BITS),
    .IDXW       (IDXW),
    .NW         (NW)
  ) u_walk (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_tvalid),
    .req_ready (s_tready),
    .req       (req),
    .req_addr  (req_addr),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  ipv6lpm_node_ram #(
    .DEPTH (NODE_COUNT),
    .WIDTH (NW),
    .AW    (IDXW)
  ) u_node_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register: free when empty or being taken this cycle
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_tdata = {out_q.match_scope, out_q.match_pop};
  assign m_tuser = out_q.table_full;

endmodule

### bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ipv6lpm_pkg::*;

  localparam int NODES       = NODE_COUNT_DEF;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_WAIT  = 140;
  localparam int RANDOM_REQS = 400;

  // One request as the bench sees it: control fields plus the full address
  typedef struct packed {
    req_ctl_t           ctl;
    logic [ADDR_W-1:0]  addr;
  } trie_req_t;

  // Row of the directed table; fixed marks a hand-written expectation
  typedef struct {
    trie_req_t rq;
    bit        fixed;
    res_t      want;
  } directed_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [151:0] s_tdata = '0;   // addr_hi, addr_lo, prefix_len, pop_value
  logic [0:0]   s_tuser = '0;   // req_type
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [23:0]  m_tdata;        // match_pop, match_scope
  logic [0:0]   m_tuser;        // table_full

  // Shadow trie
  int unsigned     kid0 [NODES];
  int unsigned     kid1 [NODES];
  logic [POP_W-1:0] rule_pop [NODES];
  logic [LEN_W-1:0] rule_scope [NODES];
  bit              rule_set [NODES];
  int unsigned     alloc_ptr;

  res_t              match_queue [$];
  logic [ADDR_W-1:0] rule_addrs [$];
  directed_row_t     directed_rows [$];
  int                fault_count = 0;
  int                src_idle_pct = 14;
  int                sink_idle_pct = 64;
  int                stall_cycles = 0;

  ipv6_longest_prefix_match_trie u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // Walk the shadow trie for one request and return the answer it gives
  function automatic res_t walk_trie(trie_req_t rq);
    res_t        res;
    int unsigned cur;
    int unsigned nxt;
    int          len;
    int          d;
    bit          b;
    res = '0;
    cur = 0;
    len = (rq.ctl.prefix_len > ADDR_BITS_DEF) ? ADDR_BITS_DEF : rq.ctl.prefix_len;
    if (rq.ctl.req_type == REQ_INSERT) begin
      for (d = 0; d < len; d++) begin
        b   = rq.addr[ADDR_W-1-d];
        nxt = b ? kid1[cur] : kid0[cur];
        if (nxt == 0) begin
          // pool exhausted: path nodes so far stay, rule is dropped
          if (alloc_ptr >= NODES) begin
            res.table_full = 1'b1;
            return res;
          end
          nxt = alloc_ptr;
          alloc_ptr++;
          kid0[nxt]     = 0;
          kid1[nxt]     = 0;
          rule_set[nxt] = 1'b0;
          if (b) kid1[cur] = nxt;
          else kid0[cur] = nxt;
        end
        cur = nxt;
      end
      rule_pop[cur]   = rq.ctl.pop_value;
      rule_scope[cur] = LEN_W'(len);
      rule_set[cur]   = 1'b1;
    end else begin
      // root rule counts as a match
      if (rule_set[0]) begin
        res.match_pop   = rule_pop[0];
        res.match_scope = rule_scope[0];
      end
      for (d = 0; d < len; d++) begin
        b   = rq.addr[ADDR_W-1-d];
        nxt = b ? kid1[cur] : kid0[cur];
        if (nxt == 0) break;
        cur = nxt;
        if (rule_set[cur]) begin
          res.match_pop   = rule_pop[cur];
          res.match_scope = rule_scope[cur];
        end
      end
    end
    return res;
  endfunction

  // Offer one request, hold it until taken, then record what should come back
  task automatic push_request(trie_req_t rq, bit fixed, res_t want);
    res_t pred;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {rq.ctl.pop_value, rq.ctl.prefix_len, rq.addr[63:0], rq.addr[127:64]};
    s_tuser  <= rq.ctl.req_type;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pred = walk_trie(rq);
    match_queue.push_back(fixed ? want : pred);
    if (rq.ctl.req_type == REQ_INSERT) begin
      rule_addrs.push_back(rq.addr);
      if (rule_addrs.size() > 64) void'(rule_addrs.pop_front());
    end
  endtask

  task automatic add_row(logic kind, logic [63:0] hi, logic [63:0] lo, logic [7:0] plen,
                         logic [15:0] pop, bit fixed, res_t want);
    directed_row_t r;
    r.rq.ctl.req_type   = kind;
    r.rq.ctl.prefix_len = plen;
    r.rq.ctl.pop_value  = pop;
    r.rq.addr           = {hi, lo};
    r.fixed             = fixed;
    r.want              = want;
    directed_rows.push_back(r);
  endtask

  // Random request: mostly near addresses already in the table
  function automatic trie_req_t random_request();
    trie_req_t         rq;
    logic [ADDR_W-1:0] noise;
    int                sel;
    noise = {$urandom, $urandom, $urandom, $urandom};
    rq.ctl.req_type  = ($urandom_range(99) < 40) ? REQ_INSERT : REQ_LOOKUP;
    rq.ctl.pop_value = POP_W'($urandom_range(65535));
    if (rule_addrs.size() != 0 && $urandom_range(3) != 0)
      rq.addr = rule_addrs[$urandom_range(rule_addrs.size() - 1)]
                ^ (noise & ({ADDR_W{1'b1}} >> $urandom_range(ADDR_W - 1)));
    else
      rq.addr = noise;
    sel = $urandom_range(9);
    case (sel)
      0: rq.ctl.prefix_len = LEN_W'($urandom_range(255));
      1: rq.ctl.prefix_len = LEN_W'(128);
      2: rq.ctl.prefix_len = '0;
      default: rq.ctl.prefix_len = LEN_W'($urandom_range(128));
    endcase
    return rq;
  endfunction

  // Result checker
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tuser[0], m_tdata[23:16], m_tdata[15:0]};
      if (match_queue.size() == 0) begin
        $display("%0t: unexpected result transaction, actual %h", $time, got);
        fault_count++;
      end else begin
        want = match_queue.pop_front();
        if (got.match_pop !== want.match_pop) begin
          $display("%0t: match_pop expected %h actual %h", $time, want.match_pop,
                   got.match_pop);
          fault_count++;
        end
        if (got.match_scope !== want.match_scope) begin
          $display("%0t: match_scope expected %0d actual %0d", $time, want.match_scope,
                   got.match_scope);
          fault_count++;
        end
        if (got.table_full !== want.table_full) begin
          $display("%0t: table_full expected %b actual %b", $time, want.table_full,
                   got.table_full);
          fault_count++;
        end
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Watchdog: cycles without any transaction
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    alloc_ptr   = 1;
    kid0[0]     = 0;
    kid1[0]     = 0;
    rule_set[0] = 1'b0;

    // empty table, root rule, extremes, saturation, re-insert, walk stopping early
    add_row(REQ_LOOKUP, '1, '1, 8'd128, 16'hFFFF, 1'b1, '0);
    add_row(REQ_LOOKUP, '0, '0, 8'd0, 16'h0000, 1'b1, '0);
    add_row(REQ_INSERT, '0, '0, 8'd0, 16'hFFFF, 1'b1, '0);
    add_row(REQ_LOOKUP, '1, '1, 8'd0, 16'h0000, 1'b1, '{1'b0, 8'd0, 16'hFFFF});
    add_row(REQ_LOOKUP, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 8'd255, 16'h0,
            1'b0, '0);
    add_row(REQ_INSERT, 64'h8000_0000_0000_0000, '0, 8'd1, 16'h1234, 1'b1, '0);
    add_row(REQ_INSERT, '1, '1, 8'd128, 16'hABCD, 1'b1, '0);
    add_row(REQ_LOOKUP, '1, '1, 8'd128, 16'h0, 1'b0, '0);
    add_row(REQ_LOOKUP, '1, '1, 8'd64, 16'h0, 1'b0, '0);
    add_row(REQ_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, '1, 8'd128, 16'h0, 1'b0, '0);
    add_row(REQ_INSERT, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 8'd200, 16'h0001,
            1'b1, '0);
    add_row(REQ_LOOKUP, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 8'd255, 16'h0,
            1'b0, '0);
    add_row(REQ_LOOKUP, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 8'd127, 16'h0,
            1'b0, '0);
    add_row(REQ_INSERT, 64'h8000_0000_0000_0000, '0, 8'd1, 16'h0F0F, 1'b1, '0);
    add_row(REQ_LOOKUP, 64'hC000_0000_0000_0000, '0, 8'd128, 16'h0, 1'b0, '0);
    add_row(REQ_INSERT, '0, '0, 8'd128, 16'h0000, 1'b1, '0);
    add_row(REQ_LOOKUP, '0, '0, 8'd128, 16'h0, 1'b0, '0);
    add_row(REQ_INSERT, '0, '0, 8'd128, 16'h8001, 1'b1, '0);
    add_row(REQ_LOOKUP, '0, 64'h1, 8'd128, 16'h0, 1'b0, '0);
    add_row(REQ_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, '0, 8'd64, 16'h7E57, 1'b1, '0);
    add_row(REQ_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, '1, 8'd129, 16'h0, 1'b0, '0);
    add_row(REQ_LOOKUP, '1, '0, 8'd128, 16'hFFFF, 1'b0, '0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      push_request(directed_rows[i].rq, directed_rows[i].fixed, directed_rows[i].want);

    // three idling regimes: sender light/receiver heavy, swapped, none
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct  = (ph == 0) ? 14 : (ph == 1) ? 64 : 0;
      sink_idle_pct = (ph == 0) ? 64 : (ph == 1) ? 14 : 0;
      repeat (RANDOM_REQS / 3 + ((ph == 2) ? RANDOM_REQS % 3 : 0))
        push_request(random_request(), 1'b0, '0);
    end
    s_tvalid <= 1'b0;

    while (match_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fault_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/ipv6lpm_pkg.sv
rtl/ipv6lpm_node_ram.sv
rtl/ipv6lpm_walk.sv
rtl/ipv6_longest_prefix_match_trie.sv
bench/testbench.sv
